/* design/wpp_pkg.sv */
package wpp_pkg;

	// Commands on the input channel
	typedef enum logic [1:0] {
		CMD_RESTART = 2'd0,
		CMD_BYTE    = 2'd1,
		CMD_EOF     = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Result kinds
	localparam logic [1:0] KIND_FRAME  = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_RIFF  = 3'd1;
	localparam logic [2:0] ERR_SHORT_FMT = 3'd2;
	localparam logic [2:0] ERR_NO_FMT    = 3'd3;
	localparam logic [2:0] ERR_NOT_PCM   = 3'd4;
	localparam logic [2:0] ERR_CHANNELS  = 3'd5;
	localparam logic [2:0] ERR_BITS      = 3'd6;
	localparam logic [2:0] ERR_TRUNC     = 3'd7;

	// Chunk tags, little-endian as they arrive
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [15:0] FMT_PCM = 16'd1;
	localparam int unsigned FMT_BODY_BYTES = 16;

	// Result queue depth; one item can post two results
	localparam int unsigned OUT_DEPTH = 4;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] file_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  error_code;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic [15:0] source_channels;
		logic [31:0] left_word;
		logic [31:0] right_word;
	} result_t;

	// Results posted by the parser for one item, first then second
	typedef struct packed {
		logic    first_vld;
		logic    second_vld;
		result_t first;
		result_t second;
	} push_t;

	function automatic result_t res_error(input logic [2:0] code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic result_t res_format(input logic [31:0] rate, input logic [15:0] bits,
			input logic [15:0] chans);
		result_t r;
		r = '0;
		r.kind = KIND_FORMAT;
		r.rate_hz = rate;
		r.sample_bits = bits;
		r.source_channels = chans;
		return r;
	endfunction

	function automatic result_t res_frame(input logic [31:0] left, input logic [31:0] right);
		result_t r;
		r = '0;
		r.kind = KIND_FRAME;
		r.left_word = left;
		r.right_word = right;
		return r;
	endfunction

	function automatic result_t res_end();
		result_t r;
		r = '0;
		r.kind = KIND_END;
		return r;
	endfunction

endpackage

/* design/wpp_parser.sv */
module wpp_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  wpp_pkg::item_t  item,
	output wpp_pkg::push_t  push
);

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_HDR,
		PH_FMT,
		PH_SKIP,
		PH_DATA,
		PH_DONE
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [3:0]   cnt_q, cnt_d;
	logic [31:0]  tag_q, tag_d;
	logic [31:0]  len_q, len_d;
	logic [32:0]  skip_q, skip_d;
	logic [15:0]  ftag_q, ftag_d;
	logic [15:0]  chans_q, chans_d;
	logic [31:0]  rate_q, rate_d;
	logic [15:0]  bits_q, bits_d;
	logic         fseen_q, fseen_d;
	logic [31:0]  left_q, left_d;
	logic [47:0]  frame_q, frame_d;
	logic [2:0]   fill_q, fill_d;

	logic [31:0]  byte_sh32;
	logic [15:0]  byte_sh16;
	logic [31:0]  riff_tag;
	logic [31:0]  hdr_tag;
	logic [31:0]  hdr_len;
	logic [32:0]  hdr_skip;
	logic [32:0]  fmt_skip;
	logic [32:0]  skip_dec;
	logic [31:0]  left_dec;
	logic [47:0]  frame_new;
	logic [2:0]   fill_inc;
	logic [2:0]   frame_need;
	logic         frame_done;
	logic [31:0]  left_word;
	logic [31:0]  right_word;
	logic         is24;
	wpp_pkg::push_t push_d;

	// Byte placed in its lane
	assign byte_sh32 = 32'(item.file_byte) << {cnt_q[1:0], 3'b000};
	assign byte_sh16 = 16'(item.file_byte) << {cnt_q[0], 3'b000};

	// Tag and length assembly
	assign riff_tag = ((cnt_q[1:0] == 2'd0) ? 32'd0 : tag_q) | byte_sh32;
	assign hdr_tag  = (cnt_q < 4'd4) ? (tag_q | byte_sh32) : tag_q;
	assign hdr_len  = (cnt_q < 4'd4) ? len_q : (len_q | byte_sh32);

	// Skip lengths: whole chunk plus pad, or fmt extension plus pad
	assign hdr_skip = {1'b0, hdr_len} + 33'(hdr_len[0]);
	assign fmt_skip = {1'b0, len_q} - 33'(wpp_pkg::FMT_BODY_BYTES) + 33'(len_q[0]);
	assign skip_dec = skip_q - 33'd1;
	assign left_dec = left_q - 32'd1;

	// Frame assembly
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			frame_new[8*i +: 8] = (fill_q == 3'(i)) ? item.file_byte : frame_q[8*i +: 8];
		end
	end

	assign is24 = (bits_q == 16'd24);
	assign frame_need = is24 ? ((chans_q == 16'd2) ? 3'd6 : 3'd3)
		: ((chans_q == 16'd2) ? 3'd4 : 3'd2);
	assign fill_inc = fill_q + 3'd1;
	assign frame_done = (fill_inc >= frame_need);
	assign left_word = is24 ? {frame_new[23:0], 8'h00} : {16'h0000, frame_new[15:0]};
	assign right_word = (chans_q != 16'd2) ? left_word
		: (is24 ? {frame_new[47:24], 8'h00} : {16'h0000, frame_new[31:16]});

	// Next state and results for one item
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		tag_d   = tag_q;
		len_d   = len_q;
		skip_d  = skip_q;
		ftag_d  = ftag_q;
		chans_d = chans_q;
		rate_d  = rate_q;
		bits_d  = bits_q;
		fseen_d = fseen_q;
		left_d  = left_q;
		frame_d = frame_q;
		fill_d  = fill_q;
		push_d  = '0;

		unique case (item.command)
			wpp_pkg::CMD_RESTART: begin
				phase_d = PH_RIFF;
				cnt_d   = '0;
				tag_d   = '0;
				len_d   = '0;
				skip_d  = '0;
				ftag_d  = '0;
				chans_d = '0;
				rate_d  = '0;
				bits_d  = '0;
				fseen_d = 1'b0;
				left_d  = '0;
				frame_d = '0;
				fill_d  = '0;
			end
			wpp_pkg::CMD_EOF: begin
				if (phase_q == PH_DATA) begin
					phase_d = PH_DONE;
					fill_d  = '0;
					frame_d = '0;
					push_d.first_vld = 1'b1;
					push_d.first = wpp_pkg::res_end();
				end else if (phase_q != PH_DONE) begin
					phase_d = PH_DONE;
					push_d.first_vld = 1'b1;
					push_d.first = wpp_pkg::res_error(wpp_pkg::ERR_TRUNC);
				end
			end
			wpp_pkg::CMD_BYTE: begin
				unique case (phase_q)
					PH_RIFF: begin
						tag_d = riff_tag;
						cnt_d = cnt_q + 4'd1;
						if (cnt_q == 4'd3 && riff_tag != wpp_pkg::TAG_RIFF) begin
							phase_d = PH_DONE;
							push_d.first_vld = 1'b1;
							push_d.first = wpp_pkg::res_error(wpp_pkg::ERR_BAD_RIFF);
						end else if (cnt_q == 4'd11) begin
							if (riff_tag != wpp_pkg::TAG_WAVE) begin
								phase_d = PH_DONE;
								push_d.first_vld = 1'b1;
								push_d.first = wpp_pkg::res_error(wpp_pkg::ERR_BAD_RIFF);
							end else begin
								cnt_d   = '0;
								tag_d   = '0;
								len_d   = '0;
								phase_d = PH_HDR;
							end
						end
					end
					PH_HDR: begin
						tag_d = hdr_tag;
						len_d = hdr_len;
						cnt_d = cnt_q + 4'd1;
						if (cnt_q == 4'd7) begin
							cnt_d = '0;
							if (hdr_tag == wpp_pkg::TAG_FMT) begin
								if (hdr_len < 32'(wpp_pkg::FMT_BODY_BYTES)) begin
									phase_d = PH_DONE;
									push_d.first_vld = 1'b1;
									push_d.first = wpp_pkg::res_error(wpp_pkg::ERR_SHORT_FMT);
								end else begin
									ftag_d  = '0;
									chans_d = '0;
									rate_d  = '0;
									bits_d  = '0;
									phase_d = PH_FMT;
								end
							end else if (hdr_tag == wpp_pkg::TAG_DATA) begin
								// Format checks in priority order
								priority if (!fseen_q) begin
									phase_d = PH_DONE;
									push_d.first_vld = 1'b1;
									push_d.first = wpp_pkg::res_error(wpp_pkg::ERR_NO_FMT);
								end else if (ftag_q != wpp_pkg::FMT_PCM) begin
									phase_d = PH_DONE;
									push_d.first_vld = 1'b1;
									push_d.first = wpp_pkg::res_error(wpp_pkg::ERR_NOT_PCM);
								end else if (chans_q != 16'd1 && chans_q != 16'd2) begin
									phase_d = PH_DONE;
									push_d.first_vld = 1'b1;
									push_d.first = wpp_pkg::res_error(wpp_pkg::ERR_CHANNELS);
								end else if (bits_q != 16'd16 && bits_q != 16'd24) begin
									phase_d = PH_DONE;
									push_d.first_vld = 1'b1;
									push_d.first = wpp_pkg::res_error(wpp_pkg::ERR_BITS);
								end else begin
									left_d  = hdr_len;
									frame_d = '0;
									fill_d  = '0;
									phase_d = PH_DATA;
									push_d.first_vld = 1'b1;
									push_d.first = wpp_pkg::res_format(rate_q, bits_q, chans_q);
									// Empty data chunk ends at once
									if (hdr_len == 32'd0) begin
										phase_d = PH_DONE;
										push_d.second_vld = 1'b1;
										push_d.second = wpp_pkg::res_end();
									end
								end
							end else begin
								skip_d  = hdr_skip;
								tag_d   = '0;
								len_d   = '0;
								phase_d = (hdr_skip == 33'd0) ? PH_HDR : PH_SKIP;
							end
						end
					end
					PH_FMT: begin
						unique case (cnt_q)
							4'd0, 4'd1:             ftag_d  = ftag_q | byte_sh16;
							4'd2, 4'd3:             chans_d = chans_q | byte_sh16;
							4'd4, 4'd5, 4'd6, 4'd7: rate_d  = rate_q | byte_sh32;
							4'd14, 4'd15:           bits_d  = bits_q | byte_sh16;
							default:                ;
						endcase
						cnt_d = cnt_q + 4'd1;
						if (cnt_q == 4'd15) begin
							fseen_d = 1'b1;
							skip_d  = fmt_skip;
							cnt_d   = '0;
							tag_d   = '0;
							len_d   = '0;
							phase_d = (fmt_skip == 33'd0) ? PH_HDR : PH_SKIP;
						end
					end
					PH_SKIP: begin
						skip_d = skip_dec;
						if (skip_dec == 33'd0) begin
							cnt_d   = '0;
							tag_d   = '0;
							len_d   = '0;
							phase_d = PH_HDR;
						end
					end
					PH_DATA: begin
						frame_d = frame_new;
						fill_d  = fill_inc;
						left_d  = left_dec;
						if (frame_done) begin
							fill_d  = '0;
							frame_d = '0;
							push_d.first_vld = 1'b1;
							push_d.first = wpp_pkg::res_frame(left_word, right_word);
						end
						if (left_dec == 32'd0) begin
							phase_d = PH_DONE;
							fill_d  = '0;
							if (frame_done) begin
								push_d.second_vld = 1'b1;
								push_d.second = wpp_pkg::res_end();
							end else begin
								push_d.first_vld = 1'b1;
								push_d.first = wpp_pkg::res_end();
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign push.first_vld  = step & push_d.first_vld;
	assign push.second_vld = step & push_d.second_vld;
	assign push.first      = push_d.first;
	assign push.second     = push_d.second;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			cnt_q   <= '0;
			tag_q   <= '0;
			len_q   <= '0;
			skip_q  <= '0;
			ftag_q  <= '0;
			chans_q <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			fseen_q <= 1'b0;
			left_q  <= '0;
			frame_q <= '0;
			fill_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			tag_q   <= tag_d;
			len_q   <= len_d;
			skip_q  <= skip_d;
			ftag_q  <= ftag_d;
			chans_q <= chans_d;
			rate_q  <= rate_d;
			bits_q  <= bits_d;
			fseen_q <= fseen_d;
			left_q  <= left_d;
			frame_q <= frame_d;
			fill_q  <= fill_d;
		end
	end

`ifndef SYNTHESIS
	// Finished parser only leaves on a restart
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && !(step && item.command == wpp_pkg::CMD_RESTART))
		|=> (phase_q == PH_DONE))
		else $error("parser left finished state without restart");

	// A partial frame never holds a whole stereo 24-bit frame
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < 3'd6)
		else $error("frame fill out of range");

	// Second result only rides behind a first
	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.second_vld |-> push.first_vld)
		else $error("second result without first");
`endif

endmodule

/* design/wpp_fifo.sv */
module wpp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  wpp_pkg::push_t    push,
	input  logic              pop,
	output wpp_pkg::result_t  head,
	output logic              not_empty,
	output logic              room2
);

	localparam int unsigned DEPTH = wpp_pkg::OUT_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	wpp_pkg::result_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_push;
	logic [PTR_W-1:0]  wr_ptr_nxt;

	assign n_push = CNT_W'(push.first_vld) + CNT_W'(push.second_vld);
	assign wr_ptr_nxt = PTR_W'(wr_ptr_q + 1'b1);

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= CNT_W'(DEPTH - 2));

	// Storage: up to two writes per cycle at consecutive slots
	always_ff @(posedge clk) begin
		if (push.first_vld) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.second_vld) begin
			mem_q[wr_ptr_nxt] <= push.second;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + n_push);
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			cnt_q <= cnt_q + n_push - CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	// Writes only land in free slots
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.first_vld || push.second_vld) |-> (cnt_q <= CNT_W'(DEPTH - 2)))
		else $error("result queue overflow");

	// Reads only from a filled queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("result queue underflow");

	// Fill count stays within the queue depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue count out of range");
`endif

endmodule

/* design/wav_pcm_stream_parser_top.sv */
// WAV PCM stream parser. Takes a WAV file one byte per transfer (command 1),
// with command 0 to restart for a new file and command 2 to mark end of file.
// It checks the RIFF/WAVE header, walks the chunks, reads the fmt chunk and at
// the data chunk reports either the format or an error, then emits one stereo
// frame per source frame (mono is copied to both sides; 24-bit samples come out
// MSB-justified in 32 bits). An item is accepted every cycle unless the block stalls: the input
// register feeds the parser, whose update posts up to two results into a
// four-entry result queue. Input stalls only while that queue has fewer than
// two free entries, so with the output side draining every cycle the block
// sustains one byte per cycle; a result passes through the input register and
// the result queue on its way out. Results drain one per transfer in order.
module wav_pcm_stream_parser_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  wpp_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output wpp_pkg::result_t  result
);

	logic            valid_s1;
	wpp_pkg::item_t  item_s1;
	logic            room2;
	logic            step;
	logic            pop;
	wpp_pkg::push_t  push;

	assign step       = valid_s1 & room2;
	assign item_stall = valid_s1 & ~room2;
	assign pop        = result_valid & ~result_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	wpp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.push   (push)
	);

	wpp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (result),
		.not_empty (result_valid),
		.room2     (room2)
	);

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

	// Parser phases of the expected-result model
	typedef enum logic [2:0] {
		PH_RIFF,
		PH_HDR,
		PH_FMT,
		PH_SKIP,
		PH_DATA,
		PH_DONE
	} parse_phase_t;

	typedef struct {
		wpp_pkg::item_t it;
		bit             drain_first;	// hold this one back until every result is in
	} feed_item_t;

	localparam int HOLDOFF_CYCLES = 60;
	localparam int TAIL_CYCLES = 24;
	localparam int MAX_REPORTS = 150;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	wpp_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	wpp_pkg::result_t result;

	feed_item_t       byte_feed[$];
	wpp_pkg::result_t parsed_results[$];
	int               err_count = 0;
	int               n_items = 0;
	bit               drain_next = 1'b0;

	// Mirror of the parser state
	parse_phase_t ph = PH_RIFF;
	logic [3:0]   hdr_pos;
	logic [31:0]  tag_acc;
	logic [31:0]  len_acc;
	logic [32:0]  skip_left;
	logic [15:0]  fmt_tag;
	logic [15:0]  fmt_chans;
	logic [31:0]  fmt_rate;
	logic [15:0]  fmt_bits;
	logic         fmt_seen;
	logic [31:0]  data_left;
	logic [47:0]  frame_buf;
	logic [2:0]   frame_cnt;

	wav_pcm_stream_parser_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Expected-result model
	// ---------------------------------------------------------------
	function automatic void clear_parser();
		ph = PH_RIFF;
		hdr_pos = '0;
		tag_acc = '0;
		len_acc = '0;
		skip_left = '0;
		fmt_tag = '0;
		fmt_chans = '0;
		fmt_rate = '0;
		fmt_bits = '0;
		fmt_seen = 1'b0;
		data_left = '0;
		frame_buf = '0;
		frame_cnt = '0;
	endfunction

	function automatic void post(logic [1:0] kind, logic [2:0] code, logic [31:0] rate,
			logic [15:0] bits, logic [15:0] chans, logic [31:0] lw, logic [31:0] rw);
		wpp_pkg::result_t r;
		r.kind = kind;
		r.error_code = code;
		r.rate_hz = rate;
		r.sample_bits = bits;
		r.source_channels = chans;
		r.left_word = lw;
		r.right_word = rw;
		parsed_results.push_back(r);
	endfunction

	function automatic void post_end();
		post(wpp_pkg::KIND_END, wpp_pkg::ERR_NONE, '0, '0, '0, '0, '0);
	endfunction

	function automatic void parse_fail(logic [2:0] code);
		ph = PH_DONE;
		post(wpp_pkg::KIND_ERROR, code, '0, '0, '0, '0, '0);
	endfunction

	function automatic void start_skip(logic [32:0] n);
		skip_left = n;
		hdr_pos = '0;
		tag_acc = '0;
		len_acc = '0;
		ph = (n == '0) ? PH_HDR : PH_SKIP;
	endfunction

	// A chunk header is complete
	function automatic void chunk_close();
		if (tag_acc == wpp_pkg::TAG_FMT) begin
			if (len_acc < 32'(wpp_pkg::FMT_BODY_BYTES)) begin
				parse_fail(wpp_pkg::ERR_SHORT_FMT);
			end else begin
				fmt_tag = '0;
				fmt_chans = '0;
				fmt_rate = '0;
				fmt_bits = '0;
				hdr_pos = '0;
				ph = PH_FMT;
			end
		end else if (tag_acc == wpp_pkg::TAG_DATA) begin
			if (!fmt_seen)
				parse_fail(wpp_pkg::ERR_NO_FMT);
			else if (fmt_tag != wpp_pkg::FMT_PCM)
				parse_fail(wpp_pkg::ERR_NOT_PCM);
			else if (fmt_chans < 16'd1 || fmt_chans > 16'd2)
				parse_fail(wpp_pkg::ERR_CHANNELS);
			else if (fmt_bits != 16'd16 && fmt_bits != 16'd24)
				parse_fail(wpp_pkg::ERR_BITS);
			else begin
				data_left = len_acc;
				frame_buf = '0;
				frame_cnt = '0;
				ph = PH_DATA;
				post(wpp_pkg::KIND_FORMAT, wpp_pkg::ERR_NONE, fmt_rate, fmt_bits, fmt_chans,
					'0, '0);
				if (data_left == '0) begin
					ph = PH_DONE;
					post_end();
				end
			end
		end else begin
			start_skip(33'(len_acc) + 33'(len_acc[0]));
		end
	endfunction

	function automatic logic [31:0] pcm_word(int idx);
		if (fmt_bits == 16'd24)
			return {frame_buf[idx*8+16 +: 8], frame_buf[idx*8+8 +: 8], frame_buf[idx*8 +: 8],
				8'h00};
		return {16'h0000, frame_buf[idx*8+8 +: 8], frame_buf[idx*8 +: 8]};
	endfunction

	function automatic void take_byte(logic [7:0] b);
		logic [4:0]  shift;
		logic [31:0] lw;
		logic [31:0] rw;
		int          need;
		shift = {hdr_pos[1:0], 3'b000};
		case (ph)
			PH_RIFF: begin
				if (hdr_pos[1:0] == 2'd0)
					tag_acc = '0;
				tag_acc |= 32'(b) << shift;
				if (hdr_pos == 4'd3 && tag_acc != wpp_pkg::TAG_RIFF) begin
					parse_fail(wpp_pkg::ERR_BAD_RIFF);
				end else if (hdr_pos == 4'd11) begin
					if (tag_acc != wpp_pkg::TAG_WAVE) begin
						parse_fail(wpp_pkg::ERR_BAD_RIFF);
					end else begin
						hdr_pos = '0;
						tag_acc = '0;
						len_acc = '0;
						ph = PH_HDR;
					end
				end else begin
					hdr_pos++;
				end
			end
			PH_HDR: begin
				if (hdr_pos < 4'd4)
					tag_acc |= 32'(b) << shift;
				else
					len_acc |= 32'(b) << shift;
				if (hdr_pos == 4'd7) begin
					hdr_pos = '0;
					chunk_close();
				end else begin
					hdr_pos++;
				end
			end
			PH_FMT: begin
				case (hdr_pos)
					4'd0, 4'd1: fmt_tag |= 16'(b) << {hdr_pos[0], 3'b000};
					4'd2, 4'd3: fmt_chans |= 16'(b) << {hdr_pos[0], 3'b000};
					4'd4, 4'd5, 4'd6, 4'd7: fmt_rate |= 32'(b) << shift;
					4'd14, 4'd15: fmt_bits |= 16'(b) << {hdr_pos[0], 3'b000};
					default: ;
				endcase
				if (hdr_pos == 4'd15) begin
					fmt_seen = 1'b1;
					start_skip(33'(len_acc) - 33'(wpp_pkg::FMT_BODY_BYTES) + 33'(len_acc[0]));
				end else begin
					hdr_pos++;
				end
			end
			PH_SKIP: begin
				skip_left = skip_left - 33'd1;
				if (skip_left == '0) begin
					hdr_pos = '0;
					tag_acc = '0;
					len_acc = '0;
					ph = PH_HDR;
				end
			end
			PH_DATA: begin
				frame_buf[frame_cnt*8 +: 8] = b;
				frame_cnt++;
				data_left--;
				need = (int'(fmt_bits) / 8) * int'(fmt_chans);
				if (int'(frame_cnt) >= need) begin
					lw = pcm_word(0);
					rw = (fmt_chans == 16'd2) ? pcm_word(fmt_bits == 16'd24 ? 3 : 2) : lw;
					post(wpp_pkg::KIND_FRAME, wpp_pkg::ERR_NONE, '0, '0, '0, lw, rw);
					frame_cnt = '0;
					frame_buf = '0;
				end
				if (data_left == '0) begin
					ph = PH_DONE;
					frame_cnt = '0;
					post_end();
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void parse_item(wpp_pkg::item_t it);
		case (it.command)
			wpp_pkg::CMD_RESTART: clear_parser();
			wpp_pkg::CMD_BYTE: take_byte(it.file_byte);
			wpp_pkg::CMD_EOF: begin
				if (ph == PH_DATA) begin
					ph = PH_DONE;
					frame_cnt = '0;
					frame_buf = '0;
					post_end();
				end else if (ph != PH_DONE) begin
					parse_fail(wpp_pkg::ERR_TRUNC);
				end
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------
	function automatic void emit(wpp_pkg::cmd_t c, logic [7:0] b);
		feed_item_t s;
		s.it.command = c;
		s.it.file_byte = b;
		s.drain_first = drain_next;
		drain_next = 1'b0;
		byte_feed.push_back(s);
		if (c != wpp_pkg::CMD_NONE)
			n_items++;
		// now and then an unknown command slips in
		if ($urandom_range(0, 29) == 0) begin
			s.it.command = wpp_pkg::CMD_NONE;
			s.it.file_byte = 8'($urandom);
			s.drain_first = 1'b0;
			byte_feed.push_back(s);
		end
	endfunction

	function automatic void put_u8(logic [7:0] b);
		emit(wpp_pkg::CMD_BYTE, b);
	endfunction

	function automatic void put_u16(logic [15:0] v);
		put_u8(v[7:0]);
		put_u8(v[15:8]);
	endfunction

	function automatic void put_u32(logic [31:0] v);
		put_u16(v[15:0]);
		put_u16(v[31:16]);
	endfunction

	function automatic void put_payload(int n);
		repeat (n) put_u8(8'($urandom));
	endfunction

	function automatic void put_eof();
		emit(wpp_pkg::CMD_EOF, 8'($urandom));
	endfunction

	function automatic void put_restart();
		emit(wpp_pkg::CMD_RESTART, 8'($urandom));
	endfunction

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic void put_riff_head(bit bad_wave);
		logic [31:0] wave;
		int          pos;
		wave = wpp_pkg::TAG_WAVE;
		pos = $urandom_range(0, 3);
		if (bad_wave)
			wave[pos*8 +: 8] = wave[pos*8 +: 8] ^ 8'($urandom_range(1, 255));
		put_u32(wpp_pkg::TAG_RIFF);
		put_u32($urandom);
		put_u32(wave);
	endfunction

	// fmt chunk with ext extension bytes and its pad byte
	function automatic void put_fmt(logic [15:0] tag, logic [15:0] chans, logic [31:0] rate,
			logic [15:0] bits, int ext);
		put_u32(wpp_pkg::TAG_FMT);
		put_u32(32'(16 + ext));
		put_u16(tag);
		put_u16(chans);
		put_u32(rate);
		put_u32($urandom);
		put_u16(16'($urandom));
		put_u16(bits);
		put_payload(ext + ext % 2);
	endfunction

	function automatic void put_foreign(int len);
		logic [31:0] tag;
		tag = $urandom;
		if (tag == wpp_pkg::TAG_FMT || tag == wpp_pkg::TAG_DATA)
			tag = ~tag;
		put_u32(tag);
		put_u32(32'(len));
		put_payload(len + len % 2);
	endfunction

	function automatic void put_data_head(logic [31:0] len);
		put_u32(wpp_pkg::TAG_DATA);
		put_u32(len);
	endfunction

	// One file of a given shape with random content
	function automatic void build_file(int shape);
		int          dlen;
		int          sel;
		logic [15:0] tag;
		logic [15:0] chans;
		logic [15:0] bits;
		logic [31:0] big_len;
		put_restart();
		case (shape)
			0: begin	// 16-bit mono, long data
				put_riff_head(1'b0);
				put_fmt(wpp_pkg::FMT_PCM, 16'd1, pick_rate(), 16'd16, 0);
				dlen = 2 * $urandom_range(20, 32);
				put_data_head(32'(dlen));
				put_payload(dlen);
			end
			1: begin	// 24-bit stereo, fmt extension, partial last frame likely
				put_riff_head(1'b0);
				put_foreign($urandom_range(0, 6));
				put_fmt(wpp_pkg::FMT_PCM, 16'd2, pick_rate(), 16'd24, $urandom_range(1, 3));
				dlen = $urandom_range(12, 30);
				put_data_head(32'(dlen));
				put_payload(dlen);
			end
			2: begin	// 24-bit mono after an odd-length foreign chunk
				put_riff_head(1'b0);
				put_foreign(2 * $urandom_range(0, 3) + 1);
				put_fmt(wpp_pkg::FMT_PCM, 16'd1, pick_rate(), 16'd24, 0);
				dlen = $urandom_range(3, 20);
				put_data_head(32'(dlen));
				put_payload(dlen);
			end
			3: begin	// two fmt chunks, end of file inside data, trailing bytes
				put_riff_head(1'b0);
				put_fmt(16'($urandom), 16'($urandom), $urandom, 16'($urandom),
					$urandom_range(0, 2));
				put_fmt(wpp_pkg::FMT_PCM, 16'd2, pick_rate(), 16'd16, 0);
				big_len = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom_range(8, 24);
				put_data_head(big_len);
				put_payload($urandom_range(1, 7));
				put_eof();
				put_payload($urandom_range(0, 2));
				put_eof();
			end
			4: begin	// rejected format
				put_riff_head(1'b0);
				tag = wpp_pkg::FMT_PCM;
				chans = 16'($urandom_range(1, 2));
				sel = $urandom_range(0, 2);
				bits = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom);
				if (bits == 16'd16 || bits == 16'd24)
					bits = 16'd8;
				case ($urandom_range(0, 2))
					0: begin
						tag = 16'($urandom);
						if (tag == wpp_pkg::FMT_PCM)
							tag = 16'hFFFF;
						chans = 16'($urandom);
					end
					1: begin
						sel = $urandom_range(0, 2);
						chans = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
							16'($urandom_range(3, 8));
						if ($urandom_range(0, 1) == 0)
							bits = 16'd16;
					end
					default: ;
				endcase
				put_fmt(tag, chans, pick_rate(), bits, $urandom_range(0, 1));
				put_data_head($urandom_range(0, 8));
				put_payload($urandom_range(0, 3));
				put_eof();
			end
			5: begin	// data chunk with no fmt before it
				put_riff_head(1'b0);
				if ($urandom_range(0, 1) == 0)
					put_foreign($urandom_range(0, 3));
				put_data_head(32'd4);
				put_payload(2);
				put_eof();
			end
			6: begin	// fmt chunk too short
				put_riff_head(1'b0);
				put_u32(wpp_pkg::TAG_FMT);
				put_u32($urandom_range(0, 15));
				put_payload($urandom_range(0, 3));
			end
			7: begin	// truncated file, or plain noise
				case ($urandom_range(0, 3))
					0: begin
						put_u32(wpp_pkg::TAG_RIFF);
						put_payload($urandom_range(0, 7));
						put_eof();
					end
					1, 2: begin
						put_riff_head(1'b0);
						put_u32(wpp_pkg::TAG_FMT);
						put_u32(32'd16);
						put_payload($urandom_range(0, 15));
						if ($urandom_range(0, 1) == 0)
							put_eof();
					end
					default: put_payload($urandom_range(1, 12));
				endcase
			end
			8: begin	// empty data chunk after an empty foreign chunk
				put_riff_head(1'b0);
				put_foreign(0);
				put_fmt(wpp_pkg::FMT_PCM, 16'($urandom_range(1, 2)), pick_rate(),
					($urandom_range(0, 1) == 0) ? 16'd16 : 16'd24, 0);
				put_data_head(32'd0);
				put_payload($urandom_range(0, 3));
				put_eof();
			end
			default: begin	// WAVE tag corrupted
				put_riff_head(1'b1);
				put_payload($urandom_range(0, 4));
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Sender: bursts and gaps, pops the feed queue on each transfer
	// ---------------------------------------------------------------
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : driver
		bit moved;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			clear_parser();
		end else begin
			moved = item_valid && !item_stall;
			if (moved) begin
				parse_item(item);
				void'(byte_feed.pop_front());
			end
			// a stalled transfer keeps valid and payload as they are
			if (!item_valid || moved) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (byte_feed.size() != 0 &&
						!(byte_feed[0].drain_first && parsed_results.size() != 0)) begin
					item_valid <= 1'b1;
					item <= byte_feed[0].it;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) :
							$urandom_range(1, 16);
						gap_left = $urandom_range(0, 6);
					end else begin
						burst_left--;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: compares each transfer with the oldest expected result
	// ---------------------------------------------------------------
	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	function automatic void check_result(wpp_pkg::result_t got);
		wpp_pkg::result_t want;
		if (parsed_results.size() == 0) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
			return;
		end
		want = parsed_results.pop_front();
		cmp_field("kind", 32'(want.kind), 32'(got.kind));
		cmp_field("error_code", 32'(want.error_code), 32'(got.error_code));
		cmp_field("rate_hz", want.rate_hz, got.rate_hz);
		cmp_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
		cmp_field("source_channels", 32'(want.source_channels), 32'(got.source_channels));
		cmp_field("left_word", want.left_word, got.left_word);
		cmp_field("right_word", want.right_word, got.right_word);
	endfunction

	int hold_left = 0;
	int holds_done = 0;
	int mode_left = 0;
	int stall_odds = 0;

	always @(posedge clk or negedge arst_n) begin : monitor
		bit stall_nxt;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				check_result(result);
				// long hold-off right as sample data starts, so the block backs up
				if (result.kind == wpp_pkg::KIND_FORMAT && holds_done < 2) begin
					hold_left = HOLDOFF_CYCLES;
					holds_done++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_nxt = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(5, 60);
					stall_odds = $urandom_range(0, 3);
				end
				mode_left--;
				stall_nxt = (stall_odds != 0) && ($urandom_range(0, 3) < stall_odds);
			end
			result_stall <= stall_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus, reset and end of run
	// ---------------------------------------------------------------
	initial begin : main
		int base;
		int k;
		// short directed sequences
		emit(wpp_pkg::CMD_NONE, 8'hFF);
		put_u32(wpp_pkg::TAG_RIFF ^ 32'h8000_0000);	// bad RIFF on the fourth byte
		put_u8(8'h00);								// ignored once finished
		put_eof();									// ignored once finished
		put_restart();
		put_u32(wpp_pkg::TAG_RIFF);
		put_u32(32'hFFFF_FFFF);
		put_eof();									// end of file inside the header
		put_restart();
		put_eof();									// end of file on an empty file
		put_restart();
		emit(wpp_pkg::CMD_NONE, 8'h00);

		// random files, cycling through every shape first
		base = n_items;
		k = 0;
		while (n_items - base < 400 || k < 12) begin
			drain_next = (k % 3 == 0);
			build_file((k < 10) ? k : $urandom_range(0, 9));
			k++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_feed.size() != 0 || parsed_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
